// ----- rtl/chtd_pkg.sv -----
package chtd_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_SYMBOLS   = 1024;
  localparam int DEF_MAX_CODE_BITS = 16;

  // fixed field widths
  localparam int WINDOW_BITS = 16;
  localparam int SYM_BITS    = 10;
  localparam int LEN_BITS    = 5;
  localparam int CNT_BITS    = 11;
  localparam int STAT_BITS   = 2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_DECODE = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  localparam logic [STAT_BITS-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_BITS-1:0] STATUS_BAD_LENS = 2'd1;
  localparam logic [STAT_BITS-1:0] STATUS_NO_TABLE = 2'd2;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_BAD,
    RES_NO_TABLE,
    RES_SYMBOL
  } res_kind_t;

  typedef enum logic {
    SRC_SCAN,
    SRC_FOUND
  } len_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAX_RD,
    S_MAX_CHK,
    S_TOP_CHK,
    S_LEN_RD,
    S_LEN_CHK,
    S_FILL,
    S_FIN,
    S_DEC_LEN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic      len_wr;
    logic      cnt_load;
    logic      tab_rd;
    logic      len_rd;
    len_src_t  len_src;
    logic      top_clr;
    logic      top_upd;
    logic      scan_clr;
    logic      scan_inc;
    logic      lvl_init;
    logic      lvl_inc;
    logic      fill_clr;
    logic      fill_start;
    logic      fill_wr;
    logic      out_load;
    res_kind_t out_kind;
  } chtd_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic top_bad;
    logic len_match;
    logic overflow;
    logic fill_last;
    logic lvl_last;
    logic fill_full;
  } chtd_stat_t;

endpackage

// ----- rtl/chtd_datapath.sv -----
module chtd_datapath import chtd_pkg::*; #(
  parameter int MAX_SYMBOLS   = DEF_MAX_SYMBOLS,
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  chtd_cmd_t            cmd,
  output chtd_stat_t           stat,
  input  logic [SYM_BITS-1:0]  symbol_index,
  input  logic [LEN_BITS-1:0]  code_length,
  input  logic [CNT_BITS-1:0]  symbol_count,
  input  logic [WINDOW_BITS-1:0] peek_window,
  output logic [SYM_BITS-1:0]  decoded_symbol,
  output logic [LEN_BITS-1:0]  consumed_bits,
  output logic [STAT_BITS-1:0] status
);

  localparam int SYM_W     = $clog2(MAX_SYMBOLS);
  localparam int TAB_W     = MAX_CODE_BITS;
  localparam int TAB_DEPTH = 1 << MAX_CODE_BITS;
  localparam int FILL_W    = MAX_CODE_BITS + 1;

  logic [LEN_BITS-1:0] len_mem [MAX_SYMBOLS];
  logic [SYM_BITS-1:0] tab_mem [TAB_DEPTH];

  logic [LEN_BITS-1:0] len_q;
  logic [SYM_BITS-1:0] tab_q;
  logic [SYM_W-1:0]    scan;
  logic [SYM_W-1:0]    cnt_last;
  logic [LEN_BITS-1:0] lvl;
  logic [LEN_BITS-1:0] top_len;
  logic [FILL_W-1:0]   fill;
  logic [FILL_W-1:0]   fill_end;

  logic [SYM_W+SYM_BITS-1:0] sym_ext;
  logic [SYM_W+SYM_BITS-1:0] found_ext;
  logic [SYM_W+SYM_BITS-1:0] scan_ext;
  logic [SYM_W-1:0]          len_waddr;
  logic [SYM_W-1:0]          len_raddr;
  logic                      sym_ok;
  logic [31:0]               cnt_sat;
  logic [LEN_BITS-1:0]       win_sh;
  logic [WINDOW_BITS-1:0]    win_idx;
  logic [TAB_W-1:0]          tab_raddr;
  logic [FILL_W-1:0]         span;
  logic [FILL_W-1:0]         tab_size;
  logic [FILL_W:0]           fill_sum;
  logic [FILL_W-1:0]         fill_inc;

  // address and data resizing
  assign sym_ext   = {{SYM_W{1'b0}}, symbol_index};
  assign found_ext = {{SYM_W{1'b0}}, tab_q};
  assign scan_ext  = {{SYM_BITS{1'b0}}, scan};
  assign len_waddr = sym_ext[SYM_W-1:0];
  assign len_raddr = (cmd.len_src == SRC_FOUND) ? found_ext[SYM_W-1:0] : scan;
  assign sym_ok    = 32'(symbol_index) < MAX_SYMBOLS;

  assign cnt_sat = (32'(symbol_count) > MAX_SYMBOLS) ? 32'(MAX_SYMBOLS) : 32'(symbol_count);

  // top largest_length bits of the window
  assign win_sh    = LEN_BITS'(WINDOW_BITS) - top_len;
  assign win_idx   = peek_window >> win_sh;
  assign tab_raddr = win_idx[TAB_W-1:0];

  assign span     = FILL_W'(1) << (top_len - lvl);
  assign tab_size = FILL_W'(1) << top_len;
  assign fill_sum = {1'b0, fill} + {1'b0, span};
  assign fill_inc = fill + FILL_W'(1);

  assign stat.count_zero = (symbol_count == '0);
  assign stat.scan_last  = (scan == cnt_last);
  assign stat.top_bad    = (top_len == '0) || (32'(top_len) > MAX_CODE_BITS);
  assign stat.len_match  = (len_q == lvl);
  assign stat.overflow   = fill_sum > {1'b0, tab_size};
  assign stat.fill_last  = (fill_inc == fill_end);
  assign stat.lvl_last   = (lvl == top_len);
  assign stat.fill_full  = (fill == tab_size);

  always_ff @(posedge clk) begin
    if (cmd.len_wr && sym_ok) begin
      len_mem[len_waddr] <= code_length;
    end
    if (cmd.len_rd) begin
      len_q <= len_mem[len_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      tab_mem[fill[TAB_W-1:0]] <= scan_ext[SYM_BITS-1:0];
    end
    if (cmd.tab_rd) begin
      tab_q <= tab_mem[tab_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_len <= '0;
    end else if (cmd.top_clr) begin
      top_len <= '0;
    end else if (cmd.top_upd && (len_q > top_len)) begin
      top_len <= len_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_load) begin
      cnt_last <= SYM_W'(cnt_sat - 32'd1);
    end
    if (cmd.scan_clr) begin
      scan <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + SYM_W'(1);
    end
    if (cmd.lvl_init) begin
      lvl <= LEN_BITS'(1);
    end else if (cmd.lvl_inc) begin
      lvl <= lvl + LEN_BITS'(1);
    end
    if (cmd.fill_clr) begin
      fill <= '0;
    end else if (cmd.fill_wr) begin
      fill <= fill_inc;
    end
    if (cmd.fill_start) begin
      fill_end <= fill_sum[FILL_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_kind)
        RES_ZERO: begin
          decoded_symbol <= '0;
          consumed_bits  <= '0;
          status         <= STATUS_OK;
        end
        RES_BAD: begin
          decoded_symbol <= '0;
          consumed_bits  <= '0;
          status         <= STATUS_BAD_LENS;
        end
        RES_NO_TABLE: begin
          decoded_symbol <= '0;
          consumed_bits  <= '0;
          status         <= STATUS_NO_TABLE;
        end
        RES_SYMBOL: begin
          decoded_symbol <= tab_q;
          consumed_bits  <= len_q;
          status         <= STATUS_OK;
        end
        default: begin
          decoded_symbol <= '0;
          consumed_bits  <= '0;
          status         <= STATUS_OK;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_fill_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_wr |-> (fill < tab_size))
    else $error("table write beyond the current table size");
`endif

endmodule

// ----- rtl/chtd_ctrl.sv -----
module chtd_ctrl import chtd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  output logic       out_valid,
  input  logic       out_ready,
  input  chtd_stat_t stat,
  output chtd_cmd_t  cmd
);

  state_t    state;
  state_t    state_next;
  logic      table_valid;
  logic      table_valid_next;
  res_kind_t pend_kind;
  res_kind_t pend_kind_next;
  logic      out_valid_next;
  logic      accept;
  logic      slot_free;
  opcode_t   op;

  assign op        = opcode_t'(opcode);
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      table_valid <= 1'b0;
      out_valid   <= 1'b0;
      pend_kind   <= RES_ZERO;
    end else begin
      state       <= state_next;
      table_valid <= table_valid_next;
      out_valid   <= out_valid_next;
      pend_kind   <= pend_kind_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LOAD:   state_next = S_EMIT;
            OP_BUILD:  state_next = stat.count_zero ? S_EMIT : S_MAX_RD;
            OP_DECODE: state_next = table_valid ? S_DEC_LEN : S_EMIT;
            OP_NOP:    state_next = S_EMIT;
            default:   state_next = S_EMIT;
          endcase
        end
      end
      S_MAX_RD:  state_next = S_MAX_CHK;
      S_MAX_CHK: state_next = stat.scan_last ? S_TOP_CHK : S_MAX_RD;
      S_TOP_CHK: state_next = stat.top_bad ? S_EMIT : S_LEN_RD;
      S_LEN_RD:  state_next = S_LEN_CHK;
      S_LEN_CHK: begin
        if (stat.len_match) begin
          state_next = stat.overflow ? S_EMIT : S_FILL;
        end else begin
          state_next = (stat.scan_last && stat.lvl_last) ? S_FIN : S_LEN_RD;
        end
      end
      S_FILL: begin
        if (stat.fill_last) begin
          state_next = (stat.scan_last && stat.lvl_last) ? S_FIN : S_LEN_RD;
        end
      end
      S_FIN:     state_next = S_EMIT;
      S_DEC_LEN: state_next = S_EMIT;
      S_EMIT:    state_next = slot_free ? S_IDLE : S_EMIT;
      default:   state_next = S_IDLE;
    endcase
  end

  // commands and flags
  always_comb begin
    logic advance;
    advance          = 1'b0;
    cmd              = '0;
    cmd.len_src      = SRC_SCAN;
    cmd.out_kind     = pend_kind;
    table_valid_next = table_valid;
    pend_kind_next   = pend_kind;
    out_valid_next   = out_valid && !out_ready;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LOAD: begin
              cmd.len_wr       = 1'b1;
              table_valid_next = 1'b0;
              pend_kind_next   = RES_ZERO;
            end
            OP_BUILD: begin
              table_valid_next = 1'b0;
              cmd.cnt_load     = 1'b1;
              cmd.top_clr      = 1'b1;
              cmd.scan_clr     = 1'b1;
              pend_kind_next   = RES_BAD;
            end
            OP_DECODE: begin
              cmd.tab_rd     = table_valid;
              pend_kind_next = table_valid ? RES_SYMBOL : RES_NO_TABLE;
            end
            OP_NOP: begin
              pend_kind_next = RES_ZERO;
            end
            default: begin
              pend_kind_next = RES_ZERO;
            end
          endcase
        end
      end
      S_MAX_RD: begin
        cmd.len_rd = 1'b1;
      end
      S_MAX_CHK: begin
        cmd.top_upd  = 1'b1;
        cmd.scan_inc = !stat.scan_last;
      end
      S_TOP_CHK: begin
        if (!stat.top_bad) begin
          cmd.lvl_init = 1'b1;
          cmd.scan_clr = 1'b1;
          cmd.fill_clr = 1'b1;
        end
      end
      S_LEN_RD: begin
        cmd.len_rd = 1'b1;
      end
      S_LEN_CHK: begin
        if (stat.len_match) begin
          cmd.fill_start = !stat.overflow;
        end else begin
          advance = 1'b1;
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        advance     = stat.fill_last;
      end
      S_FIN: begin
        table_valid_next = stat.fill_full;
        pend_kind_next   = stat.fill_full ? RES_ZERO : RES_BAD;
      end
      S_DEC_LEN: begin
        // length of the symbol the table gave
        cmd.len_rd  = 1'b1;
        cmd.len_src = SRC_FOUND;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // next symbol, or next length once all symbols are seen
    if (advance && !(stat.scan_last && stat.lvl_last)) begin
      if (stat.scan_last) begin
        cmd.lvl_inc  = 1'b1;
        cmd.scan_clr = 1'b1;
      end else begin
        cmd.scan_inc = 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded while holding an untaken result");

  a_valid_only_after_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(table_valid) |-> ($past(state) == S_FIN))
    else $error("table marked valid outside the final fill check");

  a_fill_with_stale_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> !table_valid)
    else $error("table filled while marked valid");
`endif

endmodule

// ----- rtl/canonical_huffman_table_decoder_core.sv -----
// channel  signals                                                   transfer
// -------  --------------------------------------------------------  ------------------------
// in       in_valid in_ready opcode symbol_index code_length          in_valid && in_ready
//          symbol_count peek_window
// out      out_valid out_ready decoded_symbol consumed_bits status    out_valid && out_ready
//
// load and no-op go straight to the result; decode makes a registered table read, then a length-store read
// build finds the largest length L, then fills the table one length at a time, using the
// single read port of the length store and the single write port of the lookup table
// one item is in flight at a time; in_ready is high only while the controller is idle
// a finished result waits in the output register, so the next item is taken before it leaves
// synchronous reset clears control state and the largest-length register only; both memories hold garbage until written

module canonical_huffman_table_decoder_core import chtd_pkg::*; #(
  parameter int MAX_SYMBOLS   = DEF_MAX_SYMBOLS,
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             opcode,
  input  logic [SYM_BITS-1:0]    symbol_index,
  input  logic [LEN_BITS-1:0]    code_length,
  input  logic [CNT_BITS-1:0]    symbol_count,
  input  logic [WINDOW_BITS-1:0] peek_window,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SYM_BITS-1:0]    decoded_symbol,
  output logic [LEN_BITS-1:0]    consumed_bits,
  output logic [STAT_BITS-1:0]   status
);

  // command and status between the sequencer and the datapath
  chtd_cmd_t  cmd;
  chtd_stat_t stat;

  // sequencer: handshakes, table valid flag, build loops
  chtd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // length store, lookup table, scan and fill counters, result register
  chtd_datapath #(
    .MAX_SYMBOLS   (MAX_SYMBOLS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .symbol_index   (symbol_index),
    .code_length    (code_length),
    .symbol_count   (symbol_count),
    .peek_window    (peek_window),
    .decoded_symbol (decoded_symbol),
    .consumed_bits  (consumed_bits),
    .status         (status)
  );

endmodule
